// ===== rtl/button_multi_tap_hold_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Button decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_MULTI_TAP_HOLD_DECODER_MACROS_SVH
`define BUTTON_MULTI_TAP_HOLD_DECODER_MACROS_SVH

// Same-cycle implication.
`define BTN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/btn_dec_pkg.sv =====
// ----------------------------------------------------------------------------
// Button decoder package
// Types, register indexes, thresholds and the action table lookup.
// ----------------------------------------------------------------------------
package btn_dec_pkg;

  localparam int TICK_WIDTH = 16;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
  localparam int TABLE_W    = 48;
  localparam int CODE_W     = 8;
  localparam int TAPS_W     = 4;
  localparam int INDEX_W    = 3;

  localparam logic [INDEX_W-1:0] REG_HOLD       = 3'd0;
  localparam logic [INDEX_W-1:0] REG_POWER_OFF  = 3'd1;
  localparam logic [INDEX_W-1:0] REG_UNPAIR     = 3'd2;
  localparam logic [INDEX_W-1:0] REG_TAP_WINDOW = 3'd3;
  localparam logic [INDEX_W-1:0] REG_ACTIONS    = 3'd4;

  localparam logic [CFG_W-1:0]   HOLD_RESET       = 16'd25;
  localparam logic [CFG_W-1:0]   POWER_OFF_RESET  = 16'd75;
  localparam logic [CFG_W-1:0]   UNPAIR_RESET     = 16'd250;
  localparam logic [CFG_W-1:0]   TAP_WINDOW_RESET = 16'd15;
  localparam logic [TABLE_W-1:0] ACTIONS_RESET    = '0;

  localparam logic [TAPS_W-1:0] TAPS_ONE       = 4'd1;
  localparam logic [TAPS_W-1:0] TAPS_HOLD_MAX  = 4'd3;
  localparam logic [TAPS_W-1:0] TAPS_POWER_OFF = 4'd4;
  localparam logic [TAPS_W-1:0] TAPS_UNPAIR    = 4'd5;
  localparam logic [TAPS_W-1:0] TAPS_SAT       = 4'd15;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_RELEASE = 2'd2,
    PH_WAIT    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_TAP       = 3'd1,
    EV_HOLD      = 3'd2,
    EV_POWER_OFF = 3'd3,
    EV_UNPAIR    = 3'd4,
    EV_IGNORED   = 3'd5
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0]   hold_ticks;
    logic [CFG_W-1:0]   power_off_ticks;
    logic [CFG_W-1:0]   unpair_ticks;
    logic [CFG_W-1:0]   tap_window_ticks;
    logic [TABLE_W-1:0] action_table;
  } cfg_t;

  typedef struct packed {
    event_t              ev;
    logic [TAPS_W-1:0]   taps;
    logic [CODE_W-1:0]   code;
  } result_t;

  // Slot (taps-1)*2+hold; zero outside one to three taps.
  function automatic logic [CODE_W-1:0] action_lookup(
    input logic [TABLE_W-1:0] tbl,
    input logic [TAPS_W-1:0]  tap_cnt,
    input logic               hold
  );
    logic [CODE_W-1:0] code;
    code = '0;
    unique case (tap_cnt)
      4'd1:    code = hold ? tbl[15:8]  : tbl[7:0];
      4'd2:    code = hold ? tbl[31:24] : tbl[23:16];
      4'd3:    code = hold ? tbl[47:40] : tbl[39:32];
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/btn_dec_cfg.sv =====
// ----------------------------------------------------------------------------
// Button decoder configuration registers
// Thresholds and action table, written one register per beat.
// ----------------------------------------------------------------------------
module btn_dec_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [btn_dec_pkg::INDEX_W-1:0]     cfg_index,
  input  logic [btn_dec_pkg::TABLE_W-1:0]     cfg_data,
  output btn_dec_pkg::cfg_t                   cfg
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_ticks       <= btn_dec_pkg::HOLD_RESET;
      cfg.power_off_ticks  <= btn_dec_pkg::POWER_OFF_RESET;
      cfg.unpair_ticks     <= btn_dec_pkg::UNPAIR_RESET;
      cfg.tap_window_ticks <= btn_dec_pkg::TAP_WINDOW_RESET;
      cfg.action_table     <= btn_dec_pkg::ACTIONS_RESET;
    end else if (wr) begin
      // Drop writes to unknown indexes.
      unique case (cfg_index)
        btn_dec_pkg::REG_HOLD:       cfg.hold_ticks <= cfg_data[btn_dec_pkg::CFG_W-1:0];
        btn_dec_pkg::REG_POWER_OFF:  cfg.power_off_ticks <= cfg_data[btn_dec_pkg::CFG_W-1:0];
        btn_dec_pkg::REG_UNPAIR:     cfg.unpair_ticks <= cfg_data[btn_dec_pkg::CFG_W-1:0];
        btn_dec_pkg::REG_TAP_WINDOW: cfg.tap_window_ticks <= cfg_data[btn_dec_pkg::CFG_W-1:0];
        btn_dec_pkg::REG_ACTIONS:    cfg.action_table <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/btn_dec_core.sv =====
// ----------------------------------------------------------------------------
// Button decoder core
// Input register, phase machine with tick and tap counters, event decode.
// ----------------------------------------------------------------------------
module btn_dec_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  pressed,
  input  logic                  take,
  input  btn_dec_pkg::cfg_t     cfg,
  output logic                  fire,
  output btn_dec_pkg::result_t  res
);

  logic                                  s1_valid;
  logic                                  s1_pressed;
  logic                                  accept;

  btn_dec_pkg::phase_t                   phase;
  btn_dec_pkg::phase_t                   phase_next;
  logic [btn_dec_pkg::TICK_WIDTH-1:0]    tick_count;
  logic [btn_dec_pkg::TICK_WIDTH-1:0]    tick_count_next;
  logic [btn_dec_pkg::TICK_WIDTH-1:0]    tick_inc;
  logic [btn_dec_pkg::TAPS_W-1:0]        tap_counter;
  logic [btn_dec_pkg::TAPS_W-1:0]        tap_counter_next;

  logic [btn_dec_pkg::CMP_W-1:0]         tick_cmp;
  logic                                  hit_power;
  logic                                  hit_unpair;
  logic                                  hit_hold;
  logic                                  window_over;

  assign in_stall = s1_valid && !take;
  assign accept   = in_valid && !in_stall;
  assign fire     = s1_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pressed <= pressed;
    end
  end

  // Tick advances on every beat, unless a press or release restarts it, and holds at all ones.
  assign tick_inc = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign tick_cmp = btn_dec_pkg::CMP_W'(tick_inc);

  assign hit_power   = (tap_counter == btn_dec_pkg::TAPS_POWER_OFF) &&
                       (tick_cmp >= btn_dec_pkg::CMP_W'(cfg.power_off_ticks));
  assign hit_unpair  = (tap_counter == btn_dec_pkg::TAPS_UNPAIR) &&
                       (tick_cmp >= btn_dec_pkg::CMP_W'(cfg.unpair_ticks));
  assign hit_hold    = (tap_counter <= btn_dec_pkg::TAPS_HOLD_MAX) &&
                       (tick_cmp >= btn_dec_pkg::CMP_W'(cfg.hold_ticks));
  assign window_over = tick_cmp > btn_dec_pkg::CMP_W'(cfg.tap_window_ticks);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      btn_dec_pkg::PH_IDLE: begin
        if (s1_pressed) phase_next = btn_dec_pkg::PH_PRESS;
      end
      btn_dec_pkg::PH_PRESS: begin
        if (!s1_pressed) begin
          phase_next = btn_dec_pkg::PH_RELEASE;
        end else if (hit_power || hit_unpair || hit_hold) begin
          phase_next = btn_dec_pkg::PH_WAIT;
        end
      end
      btn_dec_pkg::PH_RELEASE: begin
        if (s1_pressed) begin
          phase_next = btn_dec_pkg::PH_PRESS;
        end else if (window_over) begin
          phase_next = btn_dec_pkg::PH_IDLE;
        end
      end
      btn_dec_pkg::PH_WAIT: begin
        if (!s1_pressed) phase_next = btn_dec_pkg::PH_IDLE;
      end
      default: phase_next = btn_dec_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    tick_count_next  = tick_inc;
    tap_counter_next = tap_counter;
    res.ev           = btn_dec_pkg::EV_NONE;
    res.taps         = '0;
    res.code         = '0;
    unique case (phase)
      btn_dec_pkg::PH_IDLE: begin
        if (s1_pressed) begin
          tap_counter_next = btn_dec_pkg::TAPS_ONE;
          tick_count_next  = '0;
        end
      end
      btn_dec_pkg::PH_PRESS: begin
        if (!s1_pressed) begin
          tick_count_next = '0;
        end else if (hit_power) begin
          res.ev   = btn_dec_pkg::EV_POWER_OFF;
          res.taps = tap_counter;
        end else if (hit_unpair) begin
          res.ev   = btn_dec_pkg::EV_UNPAIR;
          res.taps = tap_counter;
        end else if (hit_hold) begin
          res.ev   = btn_dec_pkg::EV_HOLD;
          res.taps = tap_counter;
          res.code = btn_dec_pkg::action_lookup(cfg.action_table, tap_counter, 1'b1);
        end
      end
      btn_dec_pkg::PH_RELEASE: begin
        if (s1_pressed) begin
          if (tap_counter < btn_dec_pkg::TAPS_SAT) tap_counter_next = tap_counter + 1'b1;
          tick_count_next = '0;
        end else if (window_over) begin
          res.taps = tap_counter;
          if (tap_counter <= btn_dec_pkg::TAPS_HOLD_MAX) begin
            res.ev   = btn_dec_pkg::EV_TAP;
            res.code = btn_dec_pkg::action_lookup(cfg.action_table, tap_counter, 1'b0);
          end else begin
            res.ev = btn_dec_pkg::EV_IGNORED;
          end
          tap_counter_next = '0;
        end
      end
      btn_dec_pkg::PH_WAIT: begin
        if (!s1_pressed) tap_counter_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= btn_dec_pkg::PH_IDLE;
      tick_count  <= '0;
      tap_counter <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      tap_counter <= tap_counter_next;
    end
  end

endmodule

// ===== rtl/btn_dec_out.sv =====
// ----------------------------------------------------------------------------
// Button decoder output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module btn_dec_out (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  btn_dec_pkg::result_t               res,
  input  logic                               out_stall,
  output logic                               take,
  output logic                               out_valid,
  output logic [2:0]                         event_res,
  output logic [btn_dec_pkg::TAPS_W-1:0]     taps,
  output logic [btn_dec_pkg::CODE_W-1:0]     action_code
);

  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      event_res   <= 3'(res.ev);
      taps        <= res.taps;
      action_code <= res.code;
    end
  end

endmodule

// ===== rtl/button_multi_tap_hold_decoder.sv =====
// ----------------------------------------------------------------------------
// Multi-tap / hold button decoder
// Turns one sampled button level per poll tick into tap, hold, power-off,
// unpair and ignored-taps events.
// ----------------------------------------------------------------------------
// One input beat can be taken every clock cycle and each produces exactly one
// result beat (event_res zero when nothing happened). A beat is caught in an
// input register, its phase/counter update and event decode are combinational,
// and the result lands in an output register, where it is presented until the
// receiver takes it. The combinational update sets the rate of one beat per
// cycle; the input stalls only while both registers are full and the receiver
// stalls. Configuration writes are taken every cycle and must land while no
// beat is in flight.
// ----------------------------------------------------------------------------
`include "button_multi_tap_hold_decoder_macros.svh"

module button_multi_tap_hold_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [btn_dec_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [btn_dec_pkg::TABLE_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               pressed,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         event_res,
  output logic [btn_dec_pkg::TAPS_W-1:0]     taps,
  output logic [btn_dec_pkg::CODE_W-1:0]     action_code
);

  btn_dec_pkg::cfg_t    cfg;
  btn_dec_pkg::result_t res;
  logic                 fire;
  logic                 take;

  btn_dec_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  btn_dec_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pressed  (pressed),
    .take     (take),
    .cfg      (cfg),
    .fire     (fire),
    .res      (res)
  );

  btn_dec_out u_out (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .res         (res),
    .out_stall   (out_stall),
    .take        (take),
    .out_valid   (out_valid),
    .event_res   (event_res),
    .taps        (taps),
    .action_code (action_code)
  );

  `BTN_ASSERT_NOW(a_stall_only_when_blocked, in_stall, out_valid && out_stall, "input stalled while output free")
  `BTN_ASSERT_NEXT(a_fire_shows_result, fire, out_valid, "result beat lost")
  `BTN_ASSERT_NOW(a_none_is_empty, out_valid && (event_res == 3'(btn_dec_pkg::EV_NONE)), (taps == '0) && (action_code == '0), "empty event carries data")
  `BTN_ASSERT_NOW(a_code_only_tap_hold, out_valid && (event_res != 3'(btn_dec_pkg::EV_TAP)) && (event_res != 3'(btn_dec_pkg::EV_HOLD)), action_code == '0, "action code on non-action event")

endmodule

// ===== tb/button_multi_tap_hold_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button decoder testbench
// Feeds sampled button levels as tap, hold and noise gestures under several
// threshold settings and idle/stall mixes, predicts each event beat in a
// scoreboard and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module button_multi_tap_hold_decoder_tb;
  import btn_dec_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  // Tracks the gesture state and the queue of predicted event beats.
  class gesture_scoreboard;
    cfg_t                  cfg;
    phase_t                ph;
    logic [TICK_WIDTH-1:0] ticks;
    logic [TAPS_W-1:0]     tap_cnt;
    result_t               expected_events[$];
    int                    errors;

    function new();
      cfg.hold_ticks       = HOLD_RESET;
      cfg.power_off_ticks  = POWER_OFF_RESET;
      cfg.unpair_ticks     = UNPAIR_RESET;
      cfg.tap_window_ticks = TAP_WINDOW_RESET;
      cfg.action_table     = ACTIONS_RESET;
      ph      = PH_IDLE;
      ticks   = '0;
      tap_cnt = '0;
      errors  = 0;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] idx, logic [TABLE_W-1:0] data);
      case (idx)
        REG_HOLD:       cfg.hold_ticks       = data[CFG_W-1:0];
        REG_POWER_OFF:  cfg.power_off_ticks  = data[CFG_W-1:0];
        REG_UNPAIR:     cfg.unpair_ticks     = data[CFG_W-1:0];
        REG_TAP_WINDOW: cfg.tap_window_ticks = data[CFG_W-1:0];
        REG_ACTIONS:    cfg.action_table     = data;
        default: ;
      endcase
    endfunction

    function logic [CODE_W-1:0] table_code(logic [TAPS_W-1:0] t, logic hold);
      int slot;
      if (t == '0 || t > TAPS_HOLD_MAX) return '0;
      slot = (int'(t) - 1) * 2 + int'(hold);
      return cfg.action_table[slot*CODE_W +: CODE_W];
    endfunction

    // Advance the gesture state by one accepted level and queue its event.
    function void note_level(logic level);
      result_t r;
      r = '0;
      r.ev = EV_NONE;
      if (ticks != '1) ticks = ticks + 1'b1;
      case (ph)
        PH_IDLE: begin
          if (level) begin
            ph      = PH_PRESS;
            tap_cnt = TAPS_ONE;
            ticks   = '0;
          end
        end
        PH_PRESS: begin
          if (!level) begin
            ph    = PH_RELEASE;
            ticks = '0;
          end else if (tap_cnt == TAPS_POWER_OFF && ticks >= cfg.power_off_ticks) begin
            r.ev   = EV_POWER_OFF;
            r.taps = tap_cnt;
            ph     = PH_WAIT;
          end else if (tap_cnt == TAPS_UNPAIR && ticks >= cfg.unpair_ticks) begin
            r.ev   = EV_UNPAIR;
            r.taps = tap_cnt;
            ph     = PH_WAIT;
          end else if (tap_cnt <= TAPS_HOLD_MAX && ticks >= cfg.hold_ticks) begin
            r.ev   = EV_HOLD;
            r.taps = tap_cnt;
            r.code = table_code(tap_cnt, 1'b1);
            ph     = PH_WAIT;
          end
        end
        PH_RELEASE: begin
          if (level) begin
            if (tap_cnt != TAPS_SAT) tap_cnt = tap_cnt + 1'b1;
            ph    = PH_PRESS;
            ticks = '0;
          end else if (ticks > cfg.tap_window_ticks) begin
            r.taps = tap_cnt;
            if (tap_cnt <= TAPS_HOLD_MAX) begin
              r.ev   = EV_TAP;
              r.code = table_code(tap_cnt, 1'b0);
            end else begin
              r.ev = EV_IGNORED;
            end
            ph      = PH_IDLE;
            tap_cnt = '0;
          end
        end
        default: begin
          if (!level) begin
            ph      = PH_IDLE;
            tap_cnt = '0;
          end
        end
      endcase
      expected_events.push_back(r);
    endfunction

    function void check_result(logic [2:0] ev, logic [TAPS_W-1:0] t, logic [CODE_W-1:0] c);
      result_t r;
      if (expected_events.size() == 0) begin
        $error("unexpected result beat: event_res %0d taps %0d action_code %0d", ev, t, c);
        errors++;
        return;
      end
      r = expected_events.pop_front();
      if (ev !== r.ev) begin
        $error("event_res: expected %0d, got %0d", r.ev, ev);
        errors++;
      end
      if (t !== r.taps) begin
        $error("taps: expected %0d, got %0d", r.taps, t);
        errors++;
      end
      if (c !== r.code) begin
        $error("action_code: expected %0d, got %0d", r.code, c);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [INDEX_W-1:0]  cfg_index;
  logic [TABLE_W-1:0]  cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic                pressed;
  logic                out_valid;
  logic                out_stall;
  logic [2:0]          event_res;
  logic [TAPS_W-1:0]   taps;
  logic [CODE_W-1:0]   action_code;

  gesture_scoreboard sb = new();

  int  in_idle_pct;
  int  out_stall_pct;
  bit  pressure_on;
  bit  hold_off = 1'b0;
  int  hold_cnt = 0;
  int  phase_beats;
  int  cycle_cnt = 0;

  button_multi_tap_hold_decoder u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pressed    (pressed),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_res  (event_res),
    .taps       (taps),
    .action_code(action_code)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("button_multi_tap_hold_decoder test failed");
      $finish;
    end
  end

  // Hold off the receiver for one long stretch once pressure is switched on.
  always @(posedge clk) begin
    if (pressure_on && hold_cnt < 96) begin
      hold_cnt <= hold_cnt + 1;
      hold_off <= 1'b1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  // Result side: check accepted beats, stall at random or during the hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(event_res, taps, action_code);
      if (hold_off) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
      end
    end
  end

  task automatic send_beat(logic level);
    int gap;
    if ($urandom_range(99) < in_idle_pct) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      pressed  <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pressed  <= level;
    do @(posedge clk); while (in_stall);
    sb.note_level(level);
    phase_beats++;
  endtask

  task automatic send_run(logic level, int count);
    repeat (count) send_beat(level);
  endtask

  // Hold until every predicted beat has come back, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(int hold, int power_off, int unpair, int window,
                             logic [TABLE_W-1:0] actions);
    logic [TABLE_W-1:0] vals[5];
    logic [INDEX_W-1:0] idx[5];
    int k;
    vals = '{TABLE_W'(hold), TABLE_W'(power_off), TABLE_W'(unpair), TABLE_W'(window),
             actions};
    idx  = '{REG_HOLD, REG_POWER_OFF, REG_UNPAIR, REG_TAP_WINDOW, REG_ACTIONS};
    for (k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int press_limit(int n);
    if (n <= TAPS_HOLD_MAX) return int'(sb.cfg.hold_ticks);
    if (n == TAPS_POWER_OFF) return int'(sb.cfg.power_off_ticks);
    if (n == TAPS_UNPAIR) return int'(sb.cfg.unpair_ticks);
    return 20;
  endfunction

  // n taps; the last one either a long hold or a short press, then a closing gap.
  task automatic tap_gesture(int n, bit long_end);
    int i;
    int thr;
    int win;
    win = int'(sb.cfg.tap_window_ticks);
    for (i = 1; i <= n; i++) begin
      thr = press_limit(i);
      if (i == n && long_end) send_run(1'b1, thr + 1 + $urandom_range(3));
      else send_run(1'b1, $urandom_range(thr, 1));
      if (i == n) send_run(1'b0, win + 2 + $urandom_range(2));
      else send_run(1'b0, $urandom_range(win + 1, 1));
    end
  endtask

  task automatic noise_burst();
    int k;
    int len;
    len = $urandom_range(30, 5);
    for (k = 0; k < len; k++) send_beat(1'($urandom_range(1)));
    send_run(1'b0, int'(sb.cfg.tap_window_ticks) + 3);
  endtask

  task automatic run_phase(int beats, int idle_pct, int stall_pct);
    int n;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    phase_beats   = 0;
    send_run(1'b0, int'(sb.cfg.tap_window_ticks) + 3);
    while (phase_beats < beats) begin
      if ($urandom_range(99) < 20) begin
        noise_burst();
      end else begin
        n = ($urandom_range(7) == 0) ? $urandom_range(18, 12) : $urandom_range(6, 1);
        tap_gesture(n, 1'($urandom_range(1)));
      end
    end
    drain();
  endtask

  task automatic random_config();
    load_config($urandom_range(6, 1), $urandom_range(10, 1), $urandom_range(12, 1),
                $urandom_range(5, 0), TABLE_W'({$urandom, $urandom}));
  endtask

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    pressed       = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    pressure_on   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset thresholds and an empty action table.
    run_phase(100, 0, 0);

    // Directed: lowest thresholds, zero tap window, distinct codes per slot.
    load_config(1, 1, 1, 0, 48'hC6A5_8B4C_3D2E);
    in_idle_pct = 0;
    tap_gesture(1, 1'b0);
    tap_gesture(2, 1'b0);
    tap_gesture(3, 1'b0);
    tap_gesture(1, 1'b1);
    tap_gesture(3, 1'b1);
    tap_gesture(4, 1'b1);
    tap_gesture(5, 1'b1);
    tap_gesture(6, 1'b1);
    tap_gesture(4, 1'b0);
    tap_gesture(17, 1'b0);
    drain();

    // Highest thresholds: no hold fires and the tap window never closes.
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1);
    send_run(1'b1, 40);
    send_run(1'b0, 1);
    send_run(1'b1, 1);
    send_run(1'b0, 60);
    send_run(1'b1, 2);
    send_run(1'b0, 3);
    drain();

    random_config();
    pressure_on = 1'b1;
    run_phase(200, 0, 0);
    random_config();
    run_phase(200, 45, 0);
    random_config();
    run_phase(200, 0, 45);
    random_config();
    run_phase(200, 16, 16);

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_events.size() == 0) begin
      $display("button_multi_tap_hold_decoder test passed");
    end else begin
      $display("button_multi_tap_hold_decoder test failed");
    end
    $finish;
  end

endmodule
